@@ src/pwc_pkg.sv @@
// Shared constants, payload types and helper functions for the permutation window counter.
package pwc_pkg;

  // Alphabet size, which is also the window length.
  localparam int SYMBOLS = 6;
  // Width of the saturating length and wasted counters.
  localparam int COUNT_WIDTH = 16;

  // Fixed field widths of the transactions.
  localparam int SYM_W   = 4;
  localparam int LEN_W   = 16;
  localparam int WASTE_W = 16;
  localparam int FOUND_W = 10;

  // Factorial, for the permutation count and the Lehmer rank weights.
  function automatic int fact(input int n);
    int f;
    f = 1;
    for (int k = 2; k <= n; k++) begin
      f = f * k;
    end
    return f;
  endfunction

  // One seen-map bit per permutation, addressed by Lehmer rank.
  localparam int PERMS  = fact(SYMBOLS);
  localparam int RANK_W = (PERMS > 1) ? $clog2(PERMS) : 1;

  localparam logic [FOUND_W-1:0]     FOUND_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef logic [SYMBOLS-1:0][SYM_W-1:0] pwc_window_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } pwc_in_t;

  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic [WASTE_W-1:0] wasted;
    logic [FOUND_W-1:0] found;
  } pwc_out_t;

endpackage

@@ src/pwc_rank.sv @@
// Permutation check and Lehmer rank of one window of symbols.
module pwc_rank (
  input  pwc_pkg::pwc_window_t           win,
  output logic                           is_perm,
  output logic [pwc_pkg::RANK_W-1:0]     rank
);

  // A window is a permutation when every value below SYMBOLS occurs in it.
  // With exactly SYMBOLS entries that also rules out repeats and out-of-range symbols.
  always_comb begin
    logic [pwc_pkg::SYMBOLS-1:0] used;
    used = '0;
    for (int i = 0; i < pwc_pkg::SYMBOLS; i++) begin
      for (int k = 0; k < pwc_pkg::SYMBOLS; k++) begin
        if (win[i] == pwc_pkg::SYM_W'(k)) begin
          used[k] = 1'b1;
        end
      end
    end
    is_perm = &used;
  end

  // Lehmer rank: entry 0 is the oldest symbol and the most significant digit.
  always_comb begin
    int acc;
    int smaller;
    acc = 0;
    for (int i = 0; i < pwc_pkg::SYMBOLS; i++) begin
      smaller = 0;
      for (int j = i + 1; j < pwc_pkg::SYMBOLS; j++) begin
        if (win[j] < win[i]) begin
          smaller = smaller + 1;
        end
      end
      acc = acc + smaller * pwc_pkg::fact(pwc_pkg::SYMBOLS - 1 - i);
    end
    rank = pwc_pkg::RANK_W'(acc);
  end

endmodule

@@ src/pwc_core.sv @@
// String state: sliding window, seen-map and saturating counters.
module pwc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  pwc_pkg::pwc_in_t  item,
  output logic              res_valid,
  output pwc_pkg::pwc_out_t res
);

  pwc_pkg::pwc_window_t                  window_r;
  pwc_pkg::pwc_window_t                  window_nxt;
  logic [pwc_pkg::PERMS-1:0]             seen_r;
  logic [pwc_pkg::COUNT_WIDTH-1:0]       sym_cnt_r;
  logic [pwc_pkg::COUNT_WIDTH-1:0]       sym_cnt_nxt;
  logic [pwc_pkg::COUNT_WIDTH-1:0]       waste_r;
  logic [pwc_pkg::COUNT_WIDTH-1:0]       waste_nxt;
  logic [pwc_pkg::FOUND_W-1:0]           found_r;
  logic [pwc_pkg::FOUND_W-1:0]           found_nxt;

  logic                                  is_perm;
  logic [pwc_pkg::RANK_W-1:0]            rank;
  logic                                  check;
  logic                                  new_perm;

  // Shift the new symbol in at the young end of the window.
  always_comb begin
    for (int i = 0; i < pwc_pkg::SYMBOLS - 1; i++) begin
      window_nxt[i] = window_r[i + 1];
    end
    window_nxt[pwc_pkg::SYMBOLS-1] = item.symbol;
  end

  pwc_rank u_rank (
    .win     (window_nxt),
    .is_perm (is_perm),
    .rank    (rank)
  );

  // The window is checked once it has been filled by this string.
  always_comb begin
    sym_cnt_nxt = (sym_cnt_r != pwc_pkg::COUNT_MAX) ? sym_cnt_r + 1'b1 : sym_cnt_r;
    check       = sym_cnt_nxt >= pwc_pkg::COUNT_WIDTH'(pwc_pkg::SYMBOLS);
    new_perm    = check && is_perm && !seen_r[rank];
    waste_nxt   = waste_r;
    found_nxt   = found_r;
    if (new_perm) begin
      if (found_r != pwc_pkg::FOUND_MAX) begin
        found_nxt = found_r + 1'b1;
      end
    end else if (check) begin
      if (waste_r != pwc_pkg::COUNT_MAX) begin
        waste_nxt = waste_r + 1'b1;
      end
    end
  end

  // Result of the string, taken by the output register on the last symbol.
  assign res_valid  = fire && item.last;
  assign res.length = pwc_pkg::LEN_W'(sym_cnt_nxt);
  assign res.wasted = pwc_pkg::WASTE_W'(waste_nxt);
  assign res.found  = found_nxt;

  // State update; the last symbol of a string returns everything to reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      seen_r    <= '0;
      sym_cnt_r <= '0;
      waste_r   <= '0;
      found_r   <= '0;
    end else if (fire) begin
      if (item.last) begin
        window_r  <= '0;
        seen_r    <= '0;
        sym_cnt_r <= '0;
        waste_r   <= '0;
        found_r   <= '0;
      end else begin
        window_r  <= window_nxt;
        sym_cnt_r <= sym_cnt_nxt;
        waste_r   <= waste_nxt;
        found_r   <= found_nxt;
        if (new_perm) begin
          seen_r[rank] <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/permutation_window_counter.sv @@
// Top level: input register, string state and result register.
// A result passes through the input register and the result register; a last symbol may wait behind an unread result.
// Throughput: one symbol per cycle while the input side is not stalled; the seen-map is a flip-flop vector.
// The input side stalls only while a last symbol waits behind an unread result.
// Reset is synchronous and active low; it clears the window, counters and seen-map at once.
module permutation_window_counter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pwc_pkg::pwc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pwc_pkg::pwc_out_t out_data
);

  pwc_pkg::pwc_in_t  hold_r;
  logic              hold_valid_r;
  logic              hold_valid_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  pwc_pkg::pwc_out_t out_data_r;

  logic              proc;
  logic              in_take;
  logic              res_valid;
  pwc_pkg::pwc_out_t res;

  // A held symbol is processed unless it ends a string and the result slot is blocked.
  assign proc     = hold_valid_r && (!hold_r.last || !out_valid_r || !out_stall);
  assign in_stall = hold_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_take) begin
      hold_valid_nxt = 1'b1;
    end else if (proc) begin
      hold_valid_nxt = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_r <= in_data;
    end
  end

  pwc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (proc),
    .item      (hold_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/pwc_checker.sv @@
// Port-level checker for the permutation window counter, bound to the top level.
module pwc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input pwc_pkg::pwc_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input pwc_pkg::pwc_out_t out_data
);

  // A stalled result transaction stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input side stalls only behind a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // Found never exceeds the number of permutations.
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.found <= pwc_pkg::FOUND_W'(pwc_pkg::PERMS))
    else $error("found count out of range");

  // A string shorter than the window checks no window.
  a_short_string: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.length < pwc_pkg::LEN_W'(pwc_pkg::SYMBOLS))
      |-> (out_data.wasted == '0) && (out_data.found == '0))
    else $error("short string reported checked windows");

endmodule

bind permutation_window_counter pwc_checker u_pwc_checker (.*);
